FILE: hw/rtl/keyed_slot_allocator_table_top_macros.svh
// Assertion macros shared by the keyed slot allocator table checkers.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef KEYED_SLOT_ALLOCATOR_TABLE_TOP_MACROS_SVH
`define KEYED_SLOT_ALLOCATOR_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ksat_pkg.sv
// Package for the keyed slot allocator table: sizes, status codes and the
// structs passed between the controller, the allocator and the top level.
// Depends on nothing.
package ksat_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int OCC_W       = SLOT_W + 1;
    localparam int STORE_BYTES = 12 * 1024;

    localparam int KEY_W    = 32;
    localparam int ADDR_W   = 14;
    localparam int BYTES_W  = 14;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KEY_W + ADDR_W;

    // Allocation granule.
    localparam int ALIGN_MASK = 15;
    localparam int PAD_W      = 4;
    localparam int PADDED_W   = BYTES_W + 1;
    localparam int END_W      = ((ADDR_W > PADDED_W) ? ADDR_W : PADDED_W) + 1;

    // The table is full once occupancy * 4 reaches TABLE_SLOTS * 3.
    localparam int FULL_W = OCC_W + 2;
    localparam logic [FULL_W-1:0] FULL_MARK = FULL_W'(TABLE_SLOTS * 3);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic                hit;
        logic [STATUS_W-1:0] status;
    } ksat_res_t;

    typedef struct packed {
        logic               commit;
        logic [BYTES_W-1:0] bytes;
    } ksat_alloc_req_t;

    typedef struct packed {
        logic              overflow;
        logic [ADDR_W-1:0] addr;
    } ksat_alloc_res_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } ksat_ram_wr_t;

endpackage

FILE: hw/rtl/ksat_slot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the key and store address of each table slot. No package needed.
module ksat_slot_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 46
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/ksat_alloc.sv
// Bump allocator over the store: holds next_free and the tail padding, works
// out the placement of a request and commits it on command. Uses ksat_pkg.
module ksat_alloc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ksat_pkg::ksat_alloc_req_t req,
    output ksat_pkg::ksat_alloc_res_t res
);

    import ksat_pkg::*;

    logic [ADDR_W-1:0]   next_free_reg;
    logic [ADDR_W-1:0]   next_free_next;
    logic [PAD_W-1:0]    tail_reg;
    logic [PAD_W-1:0]    tail_next;
    logic                pad_fit;
    logic [PADDED_W-1:0] padded;
    logic [END_W-1:0]    end_sum;

    always_comb
    begin
        pad_fit = req.bytes <= {{(BYTES_W - PAD_W){1'b0}}, tail_reg};
        padded  = ({1'b0, req.bytes} + PADDED_W'(ALIGN_MASK)) & ~PADDED_W'(ALIGN_MASK);
        end_sum = END_W'(next_free_reg) + END_W'(padded);

        // A request that fits the padding starts where the padding starts.
        res.overflow = !pad_fit && (end_sum > END_W'(STORE_BYTES));
        res.addr     = pad_fit ? (next_free_reg - ADDR_W'(tail_reg)) : next_free_reg;

        next_free_next = next_free_reg;
        tail_next      = tail_reg;
        if (req.commit)
        begin
            if (pad_fit)
            begin
                tail_next = tail_reg - req.bytes[PAD_W-1:0];
            end
            else
            begin
                tail_next      = padded[PAD_W-1:0] - req.bytes[PAD_W-1:0];
                next_free_next = end_sum[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            next_free_reg <= next_free_next;
            tail_reg      <= tail_next;
        end
    end

endmodule

FILE: hw/rtl/ksat_ctrl.sv
// Probe controller: walks the slot table one RAM read at a time, keeps the
// slot valid bits and the occupancy, and decides hit, insert or error.
// Uses ksat_pkg; drives the slot RAM and the allocator.
module ksat_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ksat_pkg::KEY_W-1:0]       key_hash,
    input  logic [ksat_pkg::BYTES_W-1:0]     request_bytes,
    output logic                             res_valid,
    input  logic                             res_ready,
    output ksat_pkg::ksat_res_t              res,
    output ksat_pkg::ksat_alloc_req_t        alloc_req,
    input  ksat_pkg::ksat_alloc_res_t        alloc_res,
    output ksat_pkg::ksat_ram_wr_t           ram_wr,
    output logic                             ram_re,
    output logic [ksat_pkg::SLOT_W-1:0]      ram_raddr,
    input  logic [ksat_pkg::ENTRY_W-1:0]     ram_rdata
);

    import ksat_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [TABLE_SLOTS-1:0] valid_next;
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W-1:0]       key_next;
    logic [BYTES_W-1:0]     bytes_reg;
    logic [BYTES_W-1:0]     bytes_next;
    logic [SLOT_W-1:0]      idx_reg;
    logic [SLOT_W-1:0]      idx_next;
    logic [SLOT_W-1:0]      cnt_reg;
    logic [SLOT_W-1:0]      cnt_next;
    ksat_res_t              res_reg;
    ksat_res_t              res_next;
    logic                   table_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign ram_re    = (state_reg == S_PROBE);
    assign ram_raddr = idx_reg;
    assign table_full = {occ_reg, 2'b00} >= FULL_MARK;

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        key_next         = key_reg;
        bytes_next       = bytes_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        res_next         = res_reg;
        ram_wr           = '0;
        alloc_req.commit = 1'b0;
        alloc_req.bytes  = bytes_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = key_hash;
                    bytes_next = request_bytes;
                    // The probe starts one slot after the home slot.
                    idx_next   = key_hash[SLOT_W-1:0] + SLOT_W'(1);
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    state_next = S_DONE;
                    priority if (table_full)
                    begin
                        res_next = '{addr: '0, hit: 1'b0, status: ST_FULL};
                    end
                    else if (alloc_res.overflow)
                    begin
                        res_next = '{addr: '0, hit: 1'b0, status: ST_OVERFLOW};
                    end
                    else
                    begin
                        alloc_req.commit    = 1'b1;
                        ram_wr.we           = 1'b1;
                        ram_wr.addr         = idx_reg;
                        ram_wr.data         = {key_reg, alloc_res.addr};
                        valid_next[idx_reg] = 1'b1;
                        occ_next            = occ_reg + OCC_W'(1);
                        res_next = '{addr: alloc_res.addr, hit: 1'b0, status: ST_OK};
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                priority if (ram_rdata[ENTRY_W-1:ADDR_W] == key_reg)
                begin
                    res_next   = '{addr: ram_rdata[ADDR_W-1:0], hit: 1'b1, status: ST_OK};
                    state_next = S_DONE;
                end
                else if (cnt_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    // Every slot visited without a match or a free slot.
                    res_next   = '{addr: '0, hit: 1'b0, status: ST_FULL};
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_W'(1);
                    cnt_next   = cnt_reg + SLOT_W'(1);
                    state_next = S_PROBE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        bytes_reg <= bytes_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

endmodule

FILE: hw/rtl/keyed_slot_allocator_table_top.sv
// Channel  Signals                        Direction  Payload
// in       in_valid / in_ready            into block key_hash, request_bytes
// out      out_valid / out_ready          out        store_address, was_hit, status
//
// A miss is decided at the first free slot, a hit at the compare of the matching
// slot. Each occupied slot costs one slot RAM read and one compare. One request
// is in work at a time; the next is taken once the controller is back in idle
// after the result moves out. Reset clears the valid bits, occupancy and
// allocator at once; no clearing pass. A stalled result sits in the output
// register while the block returns to idle and takes the next request; that
// request's result then waits in the controller until the register drains.
// Top level of the keyed slot allocator table; uses ksat_pkg, ksat_ctrl,
// ksat_alloc and ksat_slot_ram.
module keyed_slot_allocator_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ksat_pkg::KEY_W-1:0]        key_hash,
    input  logic [ksat_pkg::BYTES_W-1:0]      request_bytes,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ksat_pkg::ADDR_W-1:0]       store_address,
    output logic                              was_hit,
    output logic [ksat_pkg::STATUS_W-1:0]     status
);

    import ksat_pkg::*;

    logic               res_valid;
    logic               res_ready;
    ksat_res_t          res;
    ksat_alloc_req_t    alloc_req;
    ksat_alloc_res_t    alloc_res;
    ksat_ram_wr_t       ram_wr;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               out_valid_reg;
    logic               out_valid_next;
    ksat_res_t          out_res_reg;

    ksat_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_hash      (key_hash),
        .request_bytes (request_bytes),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .alloc_req     (alloc_req),
        .alloc_res     (alloc_res),
        .ram_wr        (ram_wr),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    ksat_alloc u_alloc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alloc_req),
        .res   (alloc_res)
    );

    ksat_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign store_address = out_res_reg.addr;
    assign was_hit       = out_res_reg.hit;
    assign status        = out_res_reg.status;

endmodule

FILE: hw/rtl/ksat_checker.sv
// Port-level checker for the keyed slot allocator table, bound to the top.
// Uses ksat_pkg and the assertion macros header.
`include "keyed_slot_allocator_table_top_macros.svh"

module ksat_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [ksat_pkg::KEY_W-1:0]        key_hash,
    input  logic [ksat_pkg::BYTES_W-1:0]      request_bytes,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [ksat_pkg::ADDR_W-1:0]       store_address,
    input  logic                              was_hit,
    input  logic [ksat_pkg::STATUS_W-1:0]     status
);

    import ksat_pkg::*;

    // A result waits until it is taken.
    `KSAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // Requests are handled one at a time.
    `KSAT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken too early")

    // A hit is always a clean result.
    `KSAT_ASSERT_NOW(a_hit_ok, out_valid && was_hit, status == ST_OK, "hit with error status")

    // Errors carry a zero address and no hit.
    `KSAT_ASSERT_NOW(a_err_zero, out_valid && (status == ST_FULL || status == ST_OVERFLOW), store_address == '0 && !was_hit, "error result carries data")

    // Only the three defined status codes appear.
    `KSAT_ASSERT_NOW(a_status_code, out_valid, status == ST_OK || status == ST_FULL || status == ST_OVERFLOW, "undefined status code")

endmodule

bind keyed_slot_allocator_table_top ksat_checker u_ksat_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for keyed_slot_allocator_table_top: key lookups,
// insertion by linear probing, bump allocation with padding reuse, table full
// and store overflow. Depends on ksat_pkg and the RTL top level only.
module tb;
    import ksat_pkg::*;

    // Tracks the table and allocator contents and the outcomes still owed by the block.
    class lookup_scoreboard;
        bit                slot_used [TABLE_SLOTS];
        logic [KEY_W-1:0]  slot_key  [TABLE_SLOTS];
        logic [ADDR_W-1:0] slot_addr [TABLE_SLOTS];
        int unsigned       occupancy;
        int unsigned       next_free;
        int unsigned       tail_pad;
        ksat_res_t         owed [$];
        int                errors;
        int                requests;
        int                n_hit;
        int                n_insert;
        int                n_full;
        int                n_overflow;
        int                longest_walk;

        function int pending();
            return owed.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        // Works out the outcome of one accepted request and updates the table.
        function void note_request(logic [KEY_W-1:0] key, logic [BYTES_W-1:0] bytes);
            int unsigned slot;
            int unsigned walked;
            int unsigned padded;
            int unsigned addr;
            bit          found_free;
            bit          resolved;
            ksat_res_t   res;
            slot = (key % TABLE_SLOTS + 1) % TABLE_SLOTS;
            found_free = 0;
            resolved = 0;
            res.addr = '0;
            res.hit = 1'b0;
            res.status = ST_OK;
            requests++;
            for (walked = 0; walked < TABLE_SLOTS; walked++)
            begin
                if (!slot_used[slot])
                begin
                    found_free = 1;
                    break;
                end
                if (slot_key[slot] == key)
                begin
                    res.addr = slot_addr[slot];
                    res.hit = 1'b1;
                    resolved = 1;
                    break;
                end
                slot = (slot + 1) % TABLE_SLOTS;
            end
            if (walked > longest_walk)
                longest_walk = walked;
            if (resolved)
                n_hit++;
            else if (!found_free || occupancy * 4 >= TABLE_SLOTS * 3)
            begin
                res.status = ST_FULL;
                n_full++;
            end
            else
            begin
                padded = (bytes + ALIGN_MASK) & ~ALIGN_MASK;
                if (bytes <= tail_pad)
                begin
                    // Small requests live in the padding left behind the last block.
                    addr = next_free - tail_pad;
                    tail_pad = tail_pad - bytes;
                    resolved = 1;
                end
                else if (next_free + padded > STORE_BYTES)
                begin
                    res.status = ST_OVERFLOW;
                    n_overflow++;
                end
                else
                begin
                    addr = next_free;
                    tail_pad = padded - bytes;
                    next_free = next_free + padded;
                    resolved = 1;
                end
                if (resolved)
                begin
                    slot_used[slot] = 1'b1;
                    slot_key[slot] = key;
                    slot_addr[slot] = addr[ADDR_W-1:0];
                    occupancy++;
                    res.addr = addr[ADDR_W-1:0];
                    n_insert++;
                end
            end
            owed.push_back(res);
        endfunction

        task check_result(ksat_res_t got);
            ksat_res_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("result with no request outstanding (addr %0d hit %0d status %0d)",
                                 got.addr, got.hit, got.status));
                return;
            end
            want = owed.pop_front();
            if (got.addr !== want.addr)
                report($sformatf("store_address %0d, expected %0d", got.addr, want.addr));
            if (got.hit !== want.hit)
                report($sformatf("was_hit %0d, expected %0d", got.hit, want.hit));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [KEY_W-1:0]    key_hash;
    logic [BYTES_W-1:0]  request_bytes;
    logic                out_valid;
    logic                out_ready;
    logic [ADDR_W-1:0]   store_address;
    logic                was_hit;
    logic [STATUS_W-1:0] status;

    lookup_scoreboard    sb;
    logic [KEY_W-1:0]    key_pool [300];
    bit                  send_burst;
    bit                  drain_burst;

    keyed_slot_allocator_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_hash      (key_hash),
        .request_bytes (request_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .store_address (store_address),
        .was_hit       (was_hit),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Entered and left at a falling edge; valid stays high on return.
    task send_request(logic [KEY_W-1:0] key, logic [BYTES_W-1:0] bytes);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        key_hash <= key;
        request_bytes <= bytes;
        do @(posedge clk); while (!in_ready);
        sb.note_request(key, bytes);
        @(negedge clk);
    endtask

    function logic [BYTES_W-1:0] pick_size(int zero_pct, bit allow_big);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return '0;
        else if (r < zero_pct + 15)
            return BYTES_W'($urandom_range(1, 15));
        else if (r < 90)
            return BYTES_W'($urandom_range(1, 48));
        else if (r < 97)
            return BYTES_W'($urandom_range(49, 600));
        else if (allow_big)
            return BYTES_W'($urandom_range(601, 16383));
        return BYTES_W'($urandom_range(STORE_BYTES + 1, 16383));
    endfunction

    task run_random(int count, int pool_size, int noise_pct, int zero_pct, bit allow_big);
        logic [KEY_W-1:0] key;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < noise_pct)
                key = $urandom();
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_request(key, pick_size(zero_pct, allow_big));
        end
    endtask

    task run_directed();
        send_request(32'h0000_0000, 14'd0);
        send_request(32'h0000_0000, 14'd5);
        send_request(32'hFFFF_FFFF, 14'd1);
        send_request(32'h0000_00FF, 14'd15);
        send_request(32'h0000_0100, 14'd16);
        send_request(32'h1234_5678, 14'h3FFF);
        send_request(32'h1234_5678, 14'(STORE_BYTES));
        send_request(32'h1234_5678, 14'd17);
        send_request(32'h1234_5679, 14'd0);
        send_request(32'hFFFF_FFFF, 14'd0);
        send_request(32'h0000_00FE, 14'd3);
        send_request(32'h1234_5678, 14'd100);
        send_request(32'hAAAA_AAAA, 14'h2AAA);
        send_request(32'h5555_5555, 14'h0555);
        send_request(32'h5555_5555, 14'd0);
        send_request(32'h0000_01FF, 14'd33);
    endtask

    // Result side: random stalls on out_ready, one check per accepted result.
    initial
    begin
        ksat_res_t got;
        int        stall;
        int        taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 50 == 0)
                drain_burst = ($urandom_range(0, 3) == 0);
            stall = drain_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.addr = store_address;
            got.hit = was_hit;
            got.status = status;
            sb.check_result(got);
            taken++;
        end
    end

    initial
    begin
        logic [31:0] hi;
        sb = new();
        in_valid = 1'b0;
        key_hash = '0;
        request_bytes = '0;
        out_ready = 1'b0;
        send_burst = 1'b0;
        drain_burst = 1'b0;
        rst_n = 1'b0;
        // Half the pool is bunched on a few home slots so probe chains grow long.
        for (int i = 0; i < 300; i++)
        begin
            hi = $urandom();
            if ($urandom_range(0, 1))
                key_pool[i] = {hi[31:8], 8'($urandom_range(0, 4) * 63 + $urandom_range(0, 3))};
            else
                key_pool[i] = {hi[31:8], 8'($urandom_range(0, 255))};
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(650, 120, 5, 10, 1'b0);

        // Let the block drain completely before filling the store to the last byte.
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        if (sb.next_free < STORE_BYTES && sb.occupancy * 4 < TABLE_SLOTS * 3)
        begin
            send_request($urandom(), BYTES_W'(STORE_BYTES - sb.next_free));
            send_request($urandom(), '0);
        end

        run_random(680, 300, 10, 20, 1'b1);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("Covered %0d requests: %0d hits, %0d inserts, %0d table full, %0d overflow.",
                 sb.requests, sb.n_hit, sb.n_insert, sb.n_full, sb.n_overflow);
        $display("Longest probe walk %0d slots; final occupancy %0d, bump pointer %0d.",
                 sb.longest_walk, sb.occupancy, sb.next_free);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(12 * 4000000);
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
